// ===== hw/rtl/epsc_pkg.sv =====
// Shared types and constants for the epoch seconds to calendar converter.
// Used by epsc_ctrl, epsc_dp and epoch_seconds_to_calendar_top; no dependencies.
`default_nettype none

package epsc_pkg;

	// Calendar constants
	localparam logic [11:0] BASE_YEAR         = 12'd1970;
	localparam logic [15:0] HOURS_COMMON_YEAR = 16'd8760;
	localparam logic [15:0] HOURS_LEAP_EXTRA  = 16'd24;
	localparam logic [8:0]  LEAP_DAY          = 9'd60;
	localparam logic [8:0]  FEB_29            = 9'd29;
	localparam logic [3:0]  MON_FEB           = 4'd1;
	localparam logic [3:0]  MON_DEC           = 4'd11;

	// Divisors of the shared constant divider
	localparam logic [31:0] DIV_BY_60    = 32'd60;
	localparam logic [31:0] DIV_BY_BLOCK = 32'd35064;
	localparam logic [31:0] DIV_BY_24    = 32'd24;

	// Reciprocals, rounded up: quotient is (x * RECIP) >> 37 for 60, >> 36 otherwise,
	// exact over the whole input range of each phase
	localparam logic [31:0] RECIP_60    = 32'h8888_8889;
	localparam logic [31:0] RECIP_BLOCK = 32'd1959830;
	localparam logic [31:0] RECIP_24    = 32'hAAAA_AAAB;

	// A multiply step, then a quotient step
	localparam int unsigned DIV_STEPS = 2;
	localparam logic        DIV_LAST  = 1'(DIV_STEPS - 1);

	// Seconds in one hour, for the zone offset
	localparam logic signed [17:0] SEC_PER_HOUR = 18'sd3600;

	// Register map
	localparam logic REG_ZONE_OFFSET = 1'b0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_FIN,
		S_YEAR,
		S_MONTH,
		S_DONE
	} state_t;

	// Which division is in progress
	typedef enum logic [1:0] {
		PH_SEC,
		PH_MIN,
		PH_BLK,
		PH_HOUR
	} phase_t;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_LOAD,
		DP_DIV,
		DP_FIN,
		DP_YEAR,
		DP_MONTH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		phase_t phase;
	} dp_cmd_t;

	typedef struct packed {
		logic year_done;
		logic month_done;
	} dp_stat_t;

	// Days in each month of a common year, January at index 0
	function automatic logic [4:0] month_len(input logic [3:0] mon);
		logic [4:0] len;
		case (mon)
			4'd0:    len = 5'd31;
			4'd1:    len = 5'd28;
			4'd2:    len = 5'd31;
			4'd3:    len = 5'd30;
			4'd4:    len = 5'd31;
			4'd5:    len = 5'd30;
			4'd6:    len = 5'd31;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd30;
			4'd9:    len = 5'd31;
			4'd10:   len = 5'd30;
			4'd11:   len = 5'd31;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/epsc_dp.sv =====
// Datapath of the converter: offset add, shared reciprocal divider, year and month walks.
// Driven by epsc_ctrl through epsc_pkg::dp_cmd_t; uses epsc_pkg.
`default_nettype none

module epsc_dp (
	input  wire logic                clk,
	input  wire epsc_pkg::dp_cmd_t   cmd,
	output epsc_pkg::dp_stat_t       stat,
	input  wire logic [31:0]         epoch_seconds,
	input  wire logic [4:0]          zone_offset_hours,
	output logic [11:0]              year,
	output logic [3:0]               month,
	output logic [4:0]               day_of_month,
	output logic [4:0]               hour,
	output logic [5:0]               minute,
	output logic [5:0]               second
);

	localparam logic signed [17:0] SEC_PER_HOUR_L = epsc_pkg::SEC_PER_HOUR;

	// Working registers: t_q is the dividend, later the hours left in the year
	logic [31:0] t_q;
	logic [63:0] prod_q;
	logic [31:0] quot_q;
	logic [31:0] back_q;
	logic [11:0] year_q;
	logic [8:0]  day_q;
	logic [3:0]  mon_q;
	logic        fixed_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;
	logic [5:0]  sec_q;

	logic signed [17:0] zone_ext;
	logic signed [17:0] zone_sec;
	logic [31:0]        local_sec;
	logic [31:0]        recip;
	logic [31:0]        quot;
	logic [31:0]        back;
	logic [31:0]        remain;
	logic               leap;
	logic [15:0]        year_len;
	logic [4:0]         cur_len;
	logic [8:0]         day_first;

	// Zone offset in seconds, wrapped into 32 bits with the input
	assign zone_ext  = 18'(signed'(zone_offset_hours));
	assign zone_sec  = zone_ext * SEC_PER_HOUR_L;
	assign local_sec = epoch_seconds + 32'(zone_sec);

	// Pick the reciprocal, take the quotient from the product and multiply it back
	always_comb begin
		case (cmd.phase)
			epsc_pkg::PH_SEC,
			epsc_pkg::PH_MIN: begin
				recip = epsc_pkg::RECIP_60;
				quot  = {5'd0, prod_q[63:37]};
				back  = quot * epsc_pkg::DIV_BY_60;
			end
			epsc_pkg::PH_BLK: begin
				recip = epsc_pkg::RECIP_BLOCK;
				quot  = {4'd0, prod_q[63:36]};
				back  = quot * epsc_pkg::DIV_BY_BLOCK;
			end
			epsc_pkg::PH_HOUR: begin
				recip = epsc_pkg::RECIP_24;
				quot  = {4'd0, prod_q[63:36]};
				back  = quot * epsc_pkg::DIV_BY_24;
			end
			default: begin
				recip = epsc_pkg::RECIP_60;
				quot  = {5'd0, prod_q[63:37]};
				back  = quot * epsc_pkg::DIV_BY_60;
			end
		endcase
	end

	// Remainder of the running division
	assign remain = t_q - back_q;

	// Year and month walk helpers
	assign leap      = (year_q[1:0] == 2'b00);
	assign year_len  = epsc_pkg::HOURS_COMMON_YEAR + (leap ? epsc_pkg::HOURS_LEAP_EXTRA : 16'd0);
	assign cur_len   = epsc_pkg::month_len(mon_q);
	assign day_first = quot_q[8:0] + 9'd1;

	assign stat.year_done  = (t_q[15:0] < year_len);
	assign stat.month_done = fixed_q || (mon_q == epsc_pkg::MON_DEC) ||
		({4'd0, cur_len} >= day_q);

	// Execute the command of this cycle
	always_ff @(posedge clk) begin
		case (cmd.op)
			epsc_pkg::DP_LOAD: begin
				t_q <= local_sec;
			end
			epsc_pkg::DP_DIV: begin
				// The first step registers the product, the second the quotient
				prod_q <= 64'(t_q) * 64'(recip);
				quot_q <= quot;
				back_q <= back;
			end
			epsc_pkg::DP_FIN: begin
				case (cmd.phase)
					epsc_pkg::PH_SEC: begin
						sec_q <= remain[5:0];
						t_q   <= quot_q;
					end
					epsc_pkg::PH_MIN: begin
						min_q <= remain[5:0];
						t_q   <= quot_q;
					end
					epsc_pkg::PH_BLK: begin
						year_q <= epsc_pkg::BASE_YEAR + {4'd0, quot_q[5:0], 2'b00};
						t_q    <= remain;
					end
					epsc_pkg::PH_HOUR: begin
						hour_q <= remain[4:0];
						mon_q  <= 4'd0;
						// 29 February stands apart from the month walk
						if (leap && day_first == epsc_pkg::LEAP_DAY) begin
							mon_q   <= epsc_pkg::MON_FEB;
							day_q   <= epsc_pkg::FEB_29;
							fixed_q <= 1'b1;
						end else if (leap && day_first > epsc_pkg::LEAP_DAY) begin
							day_q   <= day_first - 9'd1;
							fixed_q <= 1'b0;
						end else begin
							day_q   <= day_first;
							fixed_q <= 1'b0;
						end
					end
					default: begin
						t_q <= t_q;
					end
				endcase
			end
			epsc_pkg::DP_YEAR: begin
				t_q    <= t_q - {16'd0, year_len};
				year_q <= year_q + 12'd1;
			end
			epsc_pkg::DP_MONTH: begin
				day_q <= day_q - {4'd0, cur_len};
				mon_q <= mon_q + 4'd1;
			end
			default: begin
				t_q <= t_q;
			end
		endcase
	end

	assign year         = year_q;
	assign month        = mon_q + 4'd1;
	assign day_of_month = day_q[4:0];
	assign hour         = hour_q;
	assign minute       = min_q;
	assign second       = sec_q;

endmodule

`default_nettype wire

// ===== hw/rtl/epsc_ctrl.sv =====
// Controller of the converter: sequences divisions, year walk and month walk.
// Commands epsc_dp through epsc_pkg::dp_cmd_t; uses epsc_pkg.
`default_nettype none

module epsc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output logic                    done,
	output epsc_pkg::dp_cmd_t       cmd,
	input  wire epsc_pkg::dp_stat_t stat
);

	epsc_pkg::state_t state_q, state_d;
	epsc_pkg::phase_t phase_q, phase_d;
	logic             cnt_q, cnt_d;

	// Hold state, phase and step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= epsc_pkg::S_IDLE;
			phase_q <= epsc_pkg::PH_SEC;
			cnt_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		cmd.op    = epsc_pkg::DP_NOP;
		cmd.phase = phase_q;
		busy      = 1'b1;
		done      = 1'b0;
		case (state_q)
			epsc_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.op  = epsc_pkg::DP_LOAD;
					phase_d = epsc_pkg::PH_SEC;
					cnt_d   = 1'b0;
					state_d = epsc_pkg::S_DIV;
				end
			end
			epsc_pkg::S_DIV: begin
				cmd.op = epsc_pkg::DP_DIV;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == epsc_pkg::DIV_LAST) begin
					state_d = epsc_pkg::S_FIN;
				end
			end
			epsc_pkg::S_FIN: begin
				cmd.op = epsc_pkg::DP_FIN;
				cnt_d  = 1'b0;
				case (phase_q)
					epsc_pkg::PH_SEC: begin
						phase_d = epsc_pkg::PH_MIN;
						state_d = epsc_pkg::S_DIV;
					end
					epsc_pkg::PH_MIN: begin
						phase_d = epsc_pkg::PH_BLK;
						state_d = epsc_pkg::S_DIV;
					end
					epsc_pkg::PH_BLK: begin
						state_d = epsc_pkg::S_YEAR;
					end
					epsc_pkg::PH_HOUR: begin
						state_d = epsc_pkg::S_MONTH;
					end
					default: begin
						state_d = epsc_pkg::S_IDLE;
					end
				endcase
			end
			epsc_pkg::S_YEAR: begin
				// Subtract whole years until the remaining hours fit
				if (stat.year_done) begin
					phase_d = epsc_pkg::PH_HOUR;
					state_d = epsc_pkg::S_DIV;
				end else begin
					cmd.op = epsc_pkg::DP_YEAR;
				end
			end
			epsc_pkg::S_MONTH: begin
				// Subtract whole months until the day fits
				if (stat.month_done) begin
					state_d = epsc_pkg::S_DONE;
				end else begin
					cmd.op = epsc_pkg::DP_MONTH;
				end
			end
			epsc_pkg::S_DONE: begin
				done    = 1'b1;
				state_d = epsc_pkg::S_IDLE;
			end
			default: begin
				state_d = epsc_pkg::S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	// The strobe lasts one cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// An accepted word starts the conversion
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && state_q == epsc_pkg::S_DIV && cnt_q == 1'b0))
		else $error("accepted word did not start a division");

	// A division closes only after its multiply and quotient steps
	a_fin_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == epsc_pkg::S_FIN) |->
		($past(state_q) == epsc_pkg::S_DIV && $past(cnt_q) == epsc_pkg::DIV_LAST))
		else $error("division finished early");

	// The year walk ends within four checks
	a_year_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == epsc_pkg::S_YEAR && $past(state_q) == epsc_pkg::S_YEAR &&
		 $past(state_q, 2) == epsc_pkg::S_YEAR && $past(state_q, 3) == epsc_pkg::S_YEAR)
		|-> stat.year_done)
		else $error("year walk ran past one four-year block");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/epoch_seconds_to_calendar_top.sv =====
// Top level of the epoch seconds to calendar converter: register port and glue.
// Instantiates epsc_ctrl and epsc_dp; uses epsc_pkg.
//
//  channel   handshake                        payload
//  input     start, busy                      epoch_seconds
//  result    done (one-cycle strobe)          year, month, day_of_month, hour, minute, second
//  config    psel, penable, pwrite, pready    paddr, pwdata, prdata (zone_offset_hours at 0x0)
//
// A word goes from start to done through four passes of the shared reciprocal
// divider (a multiply step, a quotient step and a closing step each), a year walk
// and a month walk, then the strobe. busy stays high from the accept edge through
// the strobe cycle; a new word is accepted in the cycle after the strobe. The
// receiver cannot stall; results stay on the ports after the strobe until the
// next word overwrites them. Reset clears the controller and sets the zone offset
// to zero.
`default_nettype none

module epoch_seconds_to_calendar_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] epoch_seconds,
	output logic             done,
	output logic [11:0]      year,
	output logic [3:0]       month,
	output logic [4:0]       day_of_month,
	output logic [4:0]       hour,
	output logic [5:0]       minute,
	output logic [5:0]       second,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [4:0]          zone_q;
	logic                cfg_wr;
	epsc_pkg::dp_cmd_t   cmd;
	epsc_pkg::dp_stat_t  stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Hold the zone offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= 5'd0;
		end else if (cfg_wr && paddr[2] == epsc_pkg::REG_ZONE_OFFSET) begin
			zone_q <= pwdata[4:0];
		end
	end

	// Return the register value on reads
	assign prdata = (paddr[2] == epsc_pkg::REG_ZONE_OFFSET) ? {27'd0, zone_q} : 32'd0;

	epsc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	epsc_dp u_dp (
		.clk               (clk),
		.cmd               (cmd),
		.stat              (stat),
		.epoch_seconds     (epoch_seconds),
		.zone_offset_hours (zone_q),
		.year              (year),
		.month             (month),
		.day_of_month      (day_of_month),
		.hour              (hour),
		.minute            (minute),
		.second            (second)
	);

endmodule

`default_nettype wire
